### hw/rtl/pexp_pkg.sv
`default_nettype none
package pexp_pkg;

   localparam int unsigned FRAME_WIDTH_DEF  = 160;
   localparam int unsigned FRAME_HEIGHT_DEF = 160;

   localparam int unsigned LANES      = 4;
   localparam int unsigned QUAD_W     = 8;
   localparam int unsigned INDEX_W    = 2;
   localparam int unsigned COORD_W    = 9;
   localparam int unsigned COLOUR_W   = 16;
   localparam int unsigned PAL_W      = 24;
   localparam int unsigned OFF_W      = 8;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned RSP_DATA_W = 40;
   localparam int unsigned ROW_W      = LANES * COLOUR_W;

   localparam logic [OFF_W-1:0] OFF_RESET = 8'd40;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PAL_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAL_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAL_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PAL_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OFF_Y = 3'd5;

   typedef logic [COLOUR_W-1:0] rgb565_type;

   // one pixel as found by a lane
   typedef struct packed {
      logic                changed;
      logic [COORD_W-1:0]  sx;
      logic [COORD_W-1:0]  sy;
      rgb565_type          colour;
   } pix_res_type;

   // keep the top 5, 6 and 5 bits of red, green and blue
   function automatic rgb565_type to_rgb565(input logic [PAL_W-1:0] rgb);
      to_rgb565 = {rgb[23:19], rgb[15:10], rgb[7:3]};
   endfunction

endpackage
`default_nettype wire

### hw/rtl/palette_expand_dirty_pixel_emit.sv
`default_nettype none
// Expands framebuffer bytes of four 2-bit palette indices (bits 1:0 leftmost)
// into RGB565 pixel draws, sending only pixels whose colour differs from the
// last one sent for that position. Bytes are taken in frame order, the
// position wrapping after FRAME_WIDTH x FRAME_HEIGHT pixels. Four lanes
// check the four pixels of a byte in the same cycle against a row of the
// colour store, and a four-entry emit buffer puts the changed ones out one
// per cycle while rsp_tready is high, tlast on the last of the byte. The
// single result port sets the pace: a byte enters the emit buffer only when
// it is empty or its last pixel is being taken. A byte is registered ahead
// of the lanes, and its results again in the emit buffer. After reset a
// clearing pass zeroes all ceil(FRAME_WIDTH*FRAME_HEIGHT/4) store rows (6400
// at 160x160), one row a cycle; req_tready stays low meanwhile while csr_
// writes are taken as ever. Write configuration only while the block is idle.
module palette_expand_dirty_pixel_emit #(
   parameter int unsigned FRAME_WIDTH  = pexp_pkg::FRAME_WIDTH_DEF,
   parameter int unsigned FRAME_HEIGHT = pexp_pkg::FRAME_HEIGHT_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // pixel_quad [7:0]
   input  logic [pexp_pkg::QUAD_W-1:0]           req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // screen_x [8:0], screen_y [17:9], pixel_colour [33:18], zero [39:34]
   output logic [pexp_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pexp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pexp_pkg::PAL_W-1:0]            csr_data
);
   import pexp_pkg::*;

   localparam int unsigned PIXEL_COUNT = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int unsigned BYTE_COUNT  = (PIXEL_COUNT + 3) / 4;
   localparam int unsigned POS_W       = (BYTE_COUNT > 1) ? $clog2(BYTE_COUNT) : 1;
   localparam int unsigned LAST_LANES  = PIXEL_COUNT - 4 * (BYTE_COUNT - 1);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(BYTE_COUNT - 1);

   // configuration
   logic [PAL_W-1:0]   pal_ff [LANES];
   logic [OFF_W-1:0]   off_x_ff;
   logic [OFF_W-1:0]   off_y_ff;
   rgb565_type         pal565 [LANES];

   // frame position of the next byte
   logic [POS_W-1:0]   pos_ff,  pos_in;
   logic [COORD_W-1:0] col_ff,  col_in;
   logic [COORD_W-1:0] row_ff,  row_in;
   logic [COORD_W:0]   col_step;

   // byte waiting on its store row
   logic               s1_valid_ff, s1_valid_in;
   logic [QUAD_W-1:0]  s1_quad_ff;
   logic [POS_W-1:0]   s1_pos_ff;
   logic [COORD_W-1:0] s1_col_ff;
   logic [COORD_W-1:0] s1_row_ff;

   // colour store, one row of four pixels per byte
   logic [ROW_W-1:0]   store_mem [BYTE_COUNT];
   logic [ROW_W-1:0]   rd_row_ff;
   logic [ROW_W-1:0]   old_row;
   logic [ROW_W-1:0]   new_row;
   logic               wr_en;
   logic [POS_W-1:0]   wr_addr;
   logic [ROW_W-1:0]   wr_data;

   // most recent item write, for forwarding
   logic               fwd_valid_ff;
   logic [POS_W-1:0]   fwd_addr_ff;
   logic [ROW_W-1:0]   fwd_row_ff;

   // clearing pass
   logic               clr_ff;
   logic [POS_W-1:0]   clr_addr_ff;

   logic               accept;
   logic               s1_move;
   logic               can_load;
   logic [LANES-1:0]   lane_en;
   pix_res_type        lane_res [LANES];

   // ---------------- configuration port ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LANES; k++) begin
            pal_ff[k] <= '0;
         end
         off_x_ff <= OFF_RESET;
         off_y_ff <= OFF_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PAL_0: pal_ff[0] <= csr_data;
            CSR_PAL_1: pal_ff[1] <= csr_data;
            CSR_PAL_2: pal_ff[2] <= csr_data;
            CSR_PAL_3: pal_ff[3] <= csr_data;
            CSR_OFF_X: off_x_ff  <= csr_data[OFF_W-1:0];
            CSR_OFF_Y: off_y_ff  <= csr_data[OFF_W-1:0];
            default: ;  // drop writes beyond the register list
         endcase
      end
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         pal565[k] = to_rgb565(pal_ff[k]);
      end
   end

   // ---------------- input side ----------------
   // advance when the emit buffer can take the waiting byte
   assign s1_move    = s1_valid_ff && can_load;
   assign req_tready = !clr_ff && (!s1_valid_ff || can_load);
   assign accept     = req_tvalid && req_tready;

   // next byte position; column and row follow it so no divide is needed
   always_comb begin
      pos_in   = pos_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      col_step = {1'b0, col_ff} + (COORD_W+1)'(4);
      if (accept) begin
         if (pos_ff == LAST_POS) begin
            pos_in = '0;
            col_in = '0;
            row_in = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
            if (col_step >= (COORD_W+1)'(FRAME_WIDTH)) begin
               col_in = COORD_W'(col_step - (COORD_W+1)'(FRAME_WIDTH));
               row_in = row_ff + COORD_W'(1);
            end else begin
               col_in = col_step[COORD_W-1:0];
            end
         end
      end
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s1_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_quad_ff <= req_tdata;
         s1_pos_ff  <= pos_ff;
         s1_col_ff  <= col_ff;
         s1_row_ff  <= row_ff;
      end
   end

   // ---------------- colour store ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + POS_W'(1);
         if (clr_addr_ff == LAST_POS) begin
            clr_ff <= 1'b0;
         end
      end
   end

   assign wr_en   = clr_ff || s1_move;
   assign wr_addr = clr_ff ? clr_addr_ff : s1_pos_ff;
   assign wr_data = clr_ff ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (accept) begin
         rd_row_ff <= store_mem[pos_ff];
      end
   end

   // the byte ahead may have rewritten this row after it was read
   always_ff @(posedge clock) begin
      if (reset || clr_ff) begin
         fwd_valid_ff <= 1'b0;
      end else if (s1_move) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         fwd_addr_ff <= s1_pos_ff;
         fwd_row_ff  <= new_row;
      end
   end

   assign old_row = (fwd_valid_ff && (fwd_addr_ff == s1_pos_ff)) ? fwd_row_ff : rd_row_ff;

   // ---------------- pixel lanes ----------------
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      // slots past the end of the frame in a partial last byte stay silent
      assign lane_en[k] = (s1_pos_ff != LAST_POS) || (LAST_LANES > k);

      pexp_lane #(
         .FRAME_WIDTH (FRAME_WIDTH),
         .LANE        (k)
      ) u_lane (
         .enable     (lane_en[k]),
         .index      (s1_quad_ff[2*k +: INDEX_W]),
         .palette    (pal565),
         .old_colour (old_row[k*COLOUR_W +: COLOUR_W]),
         .col        (s1_col_ff),
         .row        (s1_row_ff),
         .off_x      (off_x_ff),
         .off_y      (off_y_ff),
         .result     (lane_res[k])
      );

      assign new_row[k*COLOUR_W +: COLOUR_W] =
         lane_res[k].changed ? lane_res[k].colour : old_row[k*COLOUR_W +: COLOUR_W];
   end

   // ---------------- merge and emit ----------------
   pexp_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_move),
      .lane_res   (lane_res),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTH
   a_no_accept_in_clear : assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !req_tready)
      else $error("byte taken during store clearing pass");

   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted byte lost before the lanes");

   a_pos_in_frame : assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= LAST_POS) && ({1'b0, col_ff} < (COORD_W+1)'(FRAME_WIDTH))
      && ({1'b0, row_ff} < (COORD_W+1)'(FRAME_HEIGHT)))
      else $error("frame position out of range");

   a_no_write_clash : assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !s1_valid_ff)
      else $error("item write during clearing pass");
`endif

endmodule
`default_nettype wire

### hw/rtl/pexp_lane.sv
`default_nettype none
module pexp_lane #(
   parameter int unsigned FRAME_WIDTH = pexp_pkg::FRAME_WIDTH_DEF,
   parameter int unsigned LANE        = 0
) (
   input  logic                                  enable,
   input  logic [pexp_pkg::INDEX_W-1:0]          index,
   input  pexp_pkg::rgb565_type                  palette [pexp_pkg::LANES],
   input  pexp_pkg::rgb565_type                  old_colour,
   input  logic [pexp_pkg::COORD_W-1:0]          col,
   input  logic [pexp_pkg::COORD_W-1:0]          row,
   input  logic [pexp_pkg::OFF_W-1:0]            off_x,
   input  logic [pexp_pkg::OFF_W-1:0]            off_y,
   output pexp_pkg::pix_res_type                 result
);
   import pexp_pkg::*;

   logic [COORD_W:0] x_raw;
   logic [COORD_W:0] x_pix;
   logic [COORD_W:0] y_pix;
   logic             wrap;
   rgb565_type       colour;

   // a byte spans at most one row boundary, so one subtract is enough
   assign x_raw  = {1'b0, col} + (COORD_W+1)'(LANE);
   assign wrap   = x_raw >= (COORD_W+1)'(FRAME_WIDTH);
   assign x_pix  = wrap ? x_raw - (COORD_W+1)'(FRAME_WIDTH) : x_raw;
   assign y_pix  = {1'b0, row} + {{COORD_W{1'b0}}, wrap};
   assign colour = palette[index];

   always_comb begin
      result.changed = enable && (colour != old_colour);
      result.colour  = colour;
      result.sx      = x_pix[COORD_W-1:0] + {{(COORD_W-OFF_W){1'b0}}, off_x};
      result.sy      = y_pix[COORD_W-1:0] + {{(COORD_W-OFF_W){1'b0}}, off_y};
   end

endmodule
`default_nettype wire

### hw/rtl/pexp_emit.sv
`default_nettype none
module pexp_emit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  load,
   input  pexp_pkg::pix_res_type                 lane_res [pexp_pkg::LANES],
   output logic                                  can_load,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // screen_x [8:0], screen_y [17:9], pixel_colour [33:18], zero [39:34]
   output logic [pexp_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tlast
);
   import pexp_pkg::*;

   logic [LANES-1:0] mask_ff, mask_in;
   pix_res_type      res_ff [LANES];
   logic [LANES-1:0] low_bit;
   logic [1:0]       sel;
   logic             last;
   logic             take;

   // lowest pending lane goes first: left to right on screen
   assign low_bit = mask_ff & (~mask_ff + LANES'(1));
   assign last    = (mask_ff & ~low_bit) == '0;

   always_comb begin
      sel = '0;
      for (int k = LANES - 1; k >= 0; k--) begin
         if (mask_ff[k]) begin
            sel = 2'(k);
         end
      end
   end

   assign rsp_tvalid = mask_ff != '0;
   assign take       = rsp_tvalid && rsp_tready;
   assign can_load   = !rsp_tvalid || (take && last);
   assign rsp_tlast  = last;
   assign rsp_tdata  = {{(RSP_DATA_W - 2*COORD_W - COLOUR_W){1'b0}},
                        res_ff[sel].colour, res_ff[sel].sy, res_ff[sel].sx};

   always_comb begin
      mask_in = mask_ff;
      if (load) begin
         for (int k = 0; k < LANES; k++) begin
            mask_in[k] = lane_res[k].changed;
         end
      end else if (take) begin
         mask_in = mask_ff & ~low_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= lane_res;
      end
   end

endmodule
`default_nettype wire
